// ===== rtl/rsi_pkg.sv =====
package rsi_pkg;

    localparam int COORD_W = 32;
    localparam int DIR_W   = 32;
    localparam int DIR_F   = 30;
    localparam int D_W     = COORD_W + 1;
    localparam int XP_W    = D_W + DIR_W + 1;
    localparam int CR_W    = XP_W - DIR_F;
    localparam int DP_W    = D_W + DIR_W + 2;
    localparam int DOT_W   = DP_W - DIR_F;
    localparam int SQ_W    = 2 * CR_W;
    localparam int RR_W    = 2 * COORD_W;
    localparam int S_W     = SQ_W + 2;
    localparam int ROOT_W  = COORD_W;
    localparam int REM_W   = 2 * COORD_W - 1;
    localparam int Q_W     = ROOT_W + 1;
    localparam int T_W     = DOT_W + 1;
    localparam int M_W     = DIR_W + T_W;
    localparam int PT_W    = M_W - DIR_F + 1;

    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] az;
        logic signed [DIR_W-1:0]   bx;
        logic signed [DIR_W-1:0]   by;
        logic signed [DIR_W-1:0]   bz;
    } ray_t;

    typedef struct packed {
        ray_t                    ray;
        logic                    neg;
        logic                    miss;
        logic signed [DOT_W-1:0] dot;
    } pass_t;

endpackage

// ===== rtl/rsi_ray_if.sv =====
interface rsi_ray_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [rsi_pkg::COORD_W-1:0]   origin_x;
    logic signed [rsi_pkg::COORD_W-1:0]   origin_y;
    logic signed [rsi_pkg::COORD_W-1:0]   origin_z;
    logic signed [rsi_pkg::DIR_W-1:0]     dir_x;
    logic signed [rsi_pkg::DIR_W-1:0]     dir_y;
    logic signed [rsi_pkg::DIR_W-1:0]     dir_z;

    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    input ready);
    modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  output ready);
endinterface

// ===== rtl/rsi_hit_if.sv =====
interface rsi_hit_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 hit;
    logic signed [rsi_pkg::COORD_W-1:0]   point_x;
    logic signed [rsi_pkg::COORD_W-1:0]   point_y;
    logic signed [rsi_pkg::COORD_W-1:0]   point_z;

    modport source (output valid, hit, point_x, point_y, point_z, input ready);
    modport sink (input valid, hit, point_x, point_y, point_z, output ready);
endinterface

// ===== rtl/ray_sphere_intersect.sv =====
// Throughput: one item per cycle while the output is not stalled; the 32-stage square root,
// one result bit per stage, sets the depth, and every stage holds its own item.
// A stalled output freezes the whole pipeline, so nothing is lost or repeated.
// Reset (rst_n low, asynchronous) clears all valid bits and sets the radius to zero.
module ray_sphere_intersect (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic signed [rsi_pkg::COORD_W-1:0]  cfg_data,
    rsi_ray_if.sink                             ray,
    rsi_hit_if.source                           result
);

    localparam int NSQ = rsi_pkg::ROOT_W;

    // The radius register; the user must write it only while the pipeline is empty (not enforced here).
    logic signed [rsi_pkg::COORD_W-1:0] radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= '0;
        end
        else if (cfg_we)
        begin
            radius_reg <= cfg_data;
        end
    end

    // One global advance: every stage moves unless the output holds an item
    // that the consumer has not taken.
    logic adv;
    assign adv       = !result.valid || result.ready;
    assign ray.ready = adv;

    // Stage 0: capture the ray, form D_z = a_z - R and the root sign choice.
    logic                               v0_reg;
    rsi_pkg::ray_t                      r0_reg;
    logic signed [rsi_pkg::D_W-1:0]     d0_reg;
    logic signed [rsi_pkg::COORD_W-1:0] rad0_reg;
    logic                               neg0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= ray.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r0_reg.ax <= ray.origin_x;
            r0_reg.ay <= ray.origin_y;
            r0_reg.az <= ray.origin_z;
            r0_reg.bx <= ray.dir_x;
            r0_reg.by <= ray.dir_y;
            r0_reg.bz <= ray.dir_z;
            d0_reg    <= rsi_pkg::D_W'(ray.origin_z) - rsi_pkg::D_W'(radius_reg);
            rad0_reg  <= radius_reg;
            // The root is negated when R and dz share a nonzero sign.
            neg0_reg  <= ((radius_reg > 0) && (ray.dir_z > 0)) ||
                         ((radius_reg < 0) && (ray.dir_z < 0));
        end
    end

    // Stage 1: all the exact products of the cross product, dot product and R^2.
    logic                                   v1_reg;
    rsi_pkg::ray_t                          r1_reg;
    logic                                   neg1_reg;
    logic signed [rsi_pkg::XP_W-1:0]        pxa_reg, pxb_reg, pya_reg, pyb_reg;
    logic signed [rsi_pkg::XP_W-1:0]        pza_reg, pzb_reg;
    logic signed [rsi_pkg::XP_W-1:0]        pd0_reg, pd1_reg, pd2_reg;
    logic signed [rsi_pkg::RR_W-1:0]        rr1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r1_reg   <= r0_reg;
            neg1_reg <= neg0_reg;
            pxa_reg  <= rsi_pkg::XP_W'(r0_reg.ay * r0_reg.bz);
            pxb_reg  <= rsi_pkg::XP_W'(d0_reg * r0_reg.by);
            pya_reg  <= rsi_pkg::XP_W'(d0_reg * r0_reg.bx);
            pyb_reg  <= rsi_pkg::XP_W'(r0_reg.ax * r0_reg.bz);
            pza_reg  <= rsi_pkg::XP_W'(r0_reg.ax * r0_reg.by);
            pzb_reg  <= rsi_pkg::XP_W'(r0_reg.ay * r0_reg.bx);
            pd0_reg  <= rsi_pkg::XP_W'(r0_reg.bz * d0_reg);
            pd1_reg  <= rsi_pkg::XP_W'(r0_reg.ax * r0_reg.bx);
            pd2_reg  <= rsi_pkg::XP_W'(r0_reg.ay * r0_reg.by);
            rr1_reg  <= rsi_pkg::RR_W'(rad0_reg * rad0_reg);
        end
    end

    // Stage 2: cross product components and dot product, floored to Q20.16 and Q21.16.
    logic                               v2_reg;
    rsi_pkg::ray_t                      r2_reg;
    logic                               neg2_reg;
    logic signed [rsi_pkg::CR_W-1:0]    c0_reg, c1_reg, c2_reg;
    logic signed [rsi_pkg::DOT_W-1:0]   dot2_reg;
    logic signed [rsi_pkg::RR_W-1:0]    rr2_reg;
    logic signed [rsi_pkg::XP_W-1:0]    dx0, dx1, dx2;
    logic signed [rsi_pkg::DP_W-1:0]    dsum;

    always_comb
    begin
        dx0  = pxa_reg - pxb_reg;
        dx1  = pya_reg - pyb_reg;
        dx2  = pza_reg - pzb_reg;
        dsum = rsi_pkg::DP_W'(pd0_reg) + rsi_pkg::DP_W'(pd1_reg) + rsi_pkg::DP_W'(pd2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r2_reg   <= r1_reg;
            neg2_reg <= neg1_reg;
            c0_reg   <= dx0[rsi_pkg::XP_W-1:rsi_pkg::DIR_F];
            c1_reg   <= dx1[rsi_pkg::XP_W-1:rsi_pkg::DIR_F];
            c2_reg   <= dx2[rsi_pkg::XP_W-1:rsi_pkg::DIR_F];
            dot2_reg <= dsum[rsi_pkg::DP_W-1:rsi_pkg::DIR_F];
            rr2_reg  <= rr1_reg;
        end
    end

    // Stage 3: squares of the cross product components.
    logic                               v3_reg;
    rsi_pkg::pass_t                     p3_reg;
    logic signed [rsi_pkg::SQ_W-1:0]    q0_reg, q1_reg, q2_reg;
    logic signed [rsi_pkg::RR_W-1:0]    rr3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p3_reg.ray  <= r2_reg;
            p3_reg.neg  <= neg2_reg;
            p3_reg.miss <= 1'b0;
            p3_reg.dot  <= dot2_reg;
            q0_reg      <= rsi_pkg::SQ_W'(c0_reg * c0_reg);
            q1_reg      <= rsi_pkg::SQ_W'(c1_reg * c1_reg);
            q2_reg      <= rsi_pkg::SQ_W'(c2_reg * c2_reg);
            rr3_reg     <= rr2_reg;
        end
    end

    // Stage 4: discriminant s = R^2 - |D x b|^2. A negative s is a miss; a
    // nonnegative s never exceeds R^2, so its low bits hold it whole.
    logic                               v4_reg;
    rsi_pkg::pass_t                     p4_reg;
    rsi_pkg::pass_t                     p4_next;
    logic [rsi_pkg::REM_W-1:0]          s4_reg;
    logic signed [rsi_pkg::S_W-1:0]     disc;

    assign disc = rsi_pkg::S_W'(rr3_reg) - rsi_pkg::S_W'(q0_reg) - rsi_pkg::S_W'(q1_reg)
                - rsi_pkg::S_W'(q2_reg);

    always_comb
    begin
        p4_next      = p3_reg;
        p4_next.miss = disc[rsi_pkg::S_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p4_reg <= p4_next;
            s4_reg <= disc[rsi_pkg::REM_W-1:0];
        end
    end

    // Square root, one bit per stage from the top. Each stage keeps the
    // partial root r and the remainder e = s - r^2, and accepts bit k when
    // (r << (k+1)) + 4^k fits in e.
    logic                       sv_reg   [NSQ];
    rsi_pkg::pass_t             sp_reg   [NSQ];
    logic [rsi_pkg::REM_W-1:0]  srem_reg [NSQ];
    logic [rsi_pkg::ROOT_W-1:0] sroot_reg[NSQ];

    genvar j;
    generate
        for (j = 0; j < NSQ; j++)
        begin : g_sqrt
            localparam int K = NSQ - 1 - j;
            logic                       vi;
            rsi_pkg::pass_t             pi;
            logic [rsi_pkg::REM_W-1:0]  remi;
            logic [rsi_pkg::ROOT_W-1:0] rooti;
            logic [2*rsi_pkg::ROOT_W-1:0] trial;
            logic                       take;

            if (j == 0)
            begin : g_first
                assign vi    = v4_reg;
                assign pi    = p4_reg;
                assign remi  = s4_reg;
                assign rooti = '0;
            end
            else
            begin : g_next
                assign vi    = sv_reg[j-1];
                assign pi    = sp_reg[j-1];
                assign remi  = srem_reg[j-1];
                assign rooti = sroot_reg[j-1];
            end

            assign trial = ((2*rsi_pkg::ROOT_W)'(rooti) << (K + 1))
                         + ((2*rsi_pkg::ROOT_W)'(1) << (2 * K));
            assign take  = (2*rsi_pkg::ROOT_W)'(remi) >= trial;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    sv_reg[j] <= 1'b0;
                end
                else if (adv)
                begin
                    sv_reg[j] <= vi;
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    sp_reg[j] <= pi;
                    if (take)
                    begin
                        srem_reg[j]     <= remi - rsi_pkg::REM_W'(trial);
                        sroot_reg[j]    <= rooti | (rsi_pkg::ROOT_W'(1) << K);
                    end
                    else
                    begin
                        srem_reg[j]     <= remi;
                        sroot_reg[j]    <= rooti;
                    end
                end
            end
        end
    endgenerate

    // Stage T: signed root and t = +-q - (b . D); t <= 0 is a miss.
    logic                               vt_reg;
    rsi_pkg::pass_t                     pt_reg;
    rsi_pkg::pass_t                     pt_next;
    logic signed [rsi_pkg::T_W-1:0]     t_reg;
    logic signed [rsi_pkg::Q_W-1:0]     qs;
    logic signed [rsi_pkg::T_W-1:0]     tn;

    always_comb
    begin
        qs = $signed({1'b0, sroot_reg[NSQ-1]});
        if (sp_reg[NSQ-1].neg)
        begin
            qs = -qs;
        end
        tn = rsi_pkg::T_W'(qs) - rsi_pkg::T_W'(sp_reg[NSQ-1].dot);
        pt_next      = sp_reg[NSQ-1];
        pt_next.miss = sp_reg[NSQ-1].miss || (tn <= 0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vt_reg <= 1'b0;
        end
        else if (adv)
        begin
            vt_reg <= sv_reg[NSQ-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pt_reg <= pt_next;
            t_reg  <= tn;
        end
    end

    // Stage M: b_i * t for each axis.
    logic                               vm_reg;
    rsi_pkg::pass_t                     pm_reg;
    logic signed [rsi_pkg::M_W-1:0]     mx_reg, my_reg, mz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm_reg <= 1'b0;
        end
        else if (adv)
        begin
            vm_reg <= vt_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pm_reg <= pt_reg;
            mx_reg <= rsi_pkg::M_W'(pt_reg.ray.bx * t_reg);
            my_reg <= rsi_pkg::M_W'(pt_reg.ray.by * t_reg);
            mz_reg <= rsi_pkg::M_W'(pt_reg.ray.bz * t_reg);
        end
    end

    // Output stage: floor the step to Q16.16, add it to the origin and
    // saturate; a miss reports the point as zero.
    localparam logic signed [rsi_pkg::PT_W-1:0] PMAX =
        rsi_pkg::PT_W'({1'b0, {(rsi_pkg::COORD_W-1){1'b1}}});
    localparam logic signed [rsi_pkg::PT_W-1:0] PMIN = -PMAX - 1;

    function automatic logic signed [rsi_pkg::COORD_W-1:0] step_sat(
        input logic signed [rsi_pkg::COORD_W-1:0] a,
        input logic signed [rsi_pkg::M_W-1:0]     m
    );
        logic signed [rsi_pkg::PT_W-1:0] v;
        logic signed [rsi_pkg::COORD_W-1:0] r;
        v = rsi_pkg::PT_W'(a) + rsi_pkg::PT_W'($signed(m[rsi_pkg::M_W-1:rsi_pkg::DIR_F]));
        if (v > PMAX)
        begin
            r = PMAX[rsi_pkg::COORD_W-1:0];
        end
        else if (v < PMIN)
        begin
            r = PMIN[rsi_pkg::COORD_W-1:0];
        end
        else
        begin
            r = v[rsi_pkg::COORD_W-1:0];
        end
        return r;
    endfunction

    logic                               vo_reg;
    logic                               hit_reg;
    logic signed [rsi_pkg::COORD_W-1:0] px_reg, py_reg, pz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vo_reg <= 1'b0;
        end
        else if (adv)
        begin
            vo_reg <= vm_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_reg <= !pm_reg.miss;
            if (pm_reg.miss)
            begin
                px_reg <= '0;
                py_reg <= '0;
                pz_reg <= '0;
            end
            else
            begin
                px_reg <= step_sat(pm_reg.ray.ax, mx_reg);
                py_reg <= step_sat(pm_reg.ray.ay, my_reg);
                pz_reg <= step_sat(pm_reg.ray.az, mz_reg);
            end
        end
    end

    assign result.valid   = vo_reg;
    assign result.hit     = hit_reg;
    assign result.point_x = px_reg;
    assign result.point_y = py_reg;
    assign result.point_z = pz_reg;

endmodule

// ===== rtl/rsi_checker.sv =====
module rsi_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_ready,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic                                 out_hit,
    input logic signed [rsi_pkg::COORD_W-1:0]   out_x,
    input logic signed [rsi_pkg::COORD_W-1:0]   out_y,
    input logic signed [rsi_pkg::COORD_W-1:0]   out_z
);

    // A missed ray always reports the point as zero.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_hit |-> (out_x == 0) && (out_y == 0) && (out_z == 0))
        else $error("miss reported with nonzero point");

    // The input side stalls exactly when a result waits untaken.
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == !(out_valid && !out_ready))
        else $error("input ready does not follow output stall");

    // A waiting result holds still until taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_hit) && $stable(out_x)
                                    && $stable(out_y) && $stable(out_z))
        else $error("stalled result changed");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

endmodule

bind ray_sphere_intersect rsi_checker u_rsi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (ray.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_hit   (result.hit),
    .out_x     (result.point_x),
    .out_y     (result.point_y),
    .out_z     (result.point_z)
);
